// ----- sv/qmn_pkg.sv -----
// ============================================================================
// qmn_pkg
// Shared widths, payload types and arithmetic steps for the quaternion
// multiply and normalise block.
// ============================================================================
package qmn_pkg;

   localparam int CW        = 16;          // component width, signed Q2.F
   localparam int FRAC      = CW - 2;
   localparam int RW        = CW + 4;      // rounded product component, signed
   localparam int AW        = CW + 3;      // magnitude of a rounded component
   localparam int SW        = 2 * CW + 2;  // exact sum of four products
   localparam int ROOTW     = CW + 4;      // square root width
   localparam int SQW       = 2 * ROOTW;   // sum of squares
   localparam int REMW      = ROOTW + 3;   // root remainder
   localparam int DRW       = ROOTW + 1;   // divider partial remainder
   localparam int QW        = CW;          // quotient bits, one extra for rounding
   localparam int TOLW      = 14;
   localparam int TOL_RESET = 16;
   localparam int QDEPTH    = 4;
   localparam int QPTRW     = 2;
   localparam int QCNTW     = 3;

   // Negate mask per result component, bit i for term i (left[i] * right[c ^ i])
   localparam logic [3:0][3:0] NEG_MASK = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

   localparam logic signed [RW-1:0] SAT_HI = RW'(2 ** (CW - 1) - 1);
   localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;
   localparam logic [ROOTW-1:0]     UNIT   = ROOTW'(2 ** FRAC);

   typedef struct packed {
      logic signed [CW-1:0] left_w;
      logic signed [CW-1:0] left_x;
      logic signed [CW-1:0] left_y;
      logic signed [CW-1:0] left_z;
      logic signed [CW-1:0] right_w;
      logic signed [CW-1:0] right_x;
      logic signed [CW-1:0] right_y;
      logic signed [CW-1:0] right_z;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] prod_w;
      logic signed [CW-1:0] prod_x;
      logic signed [CW-1:0] prod_y;
      logic signed [CW-1:0] prod_z;
      logic                 zero_magnitude;
   } rsp_type;

   typedef logic [3:0][RW-1:0] vec_type;

   typedef struct packed {
      logic [SQW-1:0]   rad;
      logic [ROOTW-1:0] root;
      logic [REMW-1:0]  rem;
   } sqrt_state_type;

   typedef struct packed {
      logic [DRW-1:0] rem;
      logic [QW-1:0]  quo;
   } div_state_type;

   typedef div_state_type [3:0] div_vec_type;

   function automatic logic [CW-1:0] saturate(input logic signed [RW-1:0] v);
      if (v > SAT_HI) begin
         return SAT_HI[CW-1:0];
      end else if (v < SAT_LO) begin
         return SAT_LO[CW-1:0];
      end
      return v[CW-1:0];
   endfunction

   function automatic logic [AW-1:0] abs_r(input logic [RW-1:0] v);
      logic [RW-1:0] m;
      m = v[RW-1] ? (~v + RW'(1)) : v;
      return m[AW-1:0];
   endfunction

   // one root bit per call
   function automatic sqrt_state_type sqrt_step(input sqrt_state_type s);
      logic [REMW-1:0] cur;
      logic [REMW-1:0] trial;
      sqrt_state_type  o;
      cur   = {s.rem[REMW-3:0], s.rad[SQW-1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      o.rad = {s.rad[SQW-3:0], 2'b00};
      if (cur >= trial) begin
         o.rem  = cur - trial;
         o.root = {s.root[ROOTW-2:0], 1'b1};
      end else begin
         o.rem  = cur;
         o.root = {s.root[ROOTW-2:0], 1'b0};
      end
      return o;
   endfunction

   // one quotient bit per call; the first step compares without a shift
   function automatic div_state_type div_step(input div_state_type s,
                                              input logic [ROOTW-1:0] d,
                                              input logic shift);
      logic [DRW-1:0] cur;
      logic [DRW-1:0] dd;
      div_state_type  o;
      cur = shift ? {s.rem[DRW-2:0], 1'b0} : s.rem;
      dd  = {1'b0, d};
      if (cur >= dd) begin
         o.rem = cur - dd;
         o.quo = {s.quo[QW-2:0], 1'b1};
      end else begin
         o.rem = cur;
         o.quo = {s.quo[QW-2:0], 1'b0};
      end
      return o;
   endfunction

endpackage

// ----- sv/quaternion_multiply_normalise.sv -----
// ============================================================================
// quaternion_multiply_normalise
// Hamilton product of two Q2.14 quaternions, normalised to unit magnitude
// unless it is zero or already within the programmed tolerance of one.
// ============================================================================
//
//  channel  direction  handshake           payload
//  req      in         req_valid/req_stall  req_data  (qmn_pkg::req_type)
//  rsp      out        rsp_valid/rsp_stall  rsp_data  (qmn_pkg::rsp_type)
//  csr      in         csr_wr_en            csr_wr_data (unit tolerance)
//
//  One transaction a cycle while req_stall is low. An accepted transaction
//  loads the product register at the accepting edge, then passes through
//  the queue, the squares and sum registers, the root stages (one bit a
//  stage), the rounding register, the division stages (one quotient bit a
//  stage) and the result register, which drives rsp_valid.
//  Synchronous active-high reset empties the queue and pipeline and sets the
//  tolerance to 16.
//  A stalled result freezes the back pipeline; the front keeps accepting
//  until the four-entry queue is committed, then raises req_stall.
//
module quaternion_multiply_normalise (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  qmn_pkg::req_type         req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output qmn_pkg::rsp_type         rsp_data,
   input  logic                     csr_wr_en,
   input  logic [qmn_pkg::TOLW-1:0] csr_wr_data
);
   import qmn_pkg::*;

   logic             push;
   vec_type          push_data;
   logic             pop;
   logic             head_valid;
   vec_type          head_data;
   logic [QCNTW-1:0] fill;

   // product and rounding
   qmn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .fill      (fill),
      .push      (push),
      .push_data (push_data)
   );

   // decouples request side from the long normalise pipeline
   qmn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .fill       (fill)
   );

   // magnitude, tolerance test, division, result register
   qmn_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head_valid  (head_valid),
      .head_data   (head_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- sv/qmn_front.sv -----
// ============================================================================
// qmn_front
// Request side: takes transactions, forms the sixteen partial products and
// the rounded Hamilton product, and pushes it into the queue.
// ============================================================================
module qmn_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  qmn_pkg::req_type             req_data,
   input  logic [qmn_pkg::QCNTW-1:0]    fill,
   output logic                         push,
   output qmn_pkg::vec_type             push_data
);
   import qmn_pkg::*;

   logic                 accept;
   logic                 v1_ff;
   logic [QCNTW:0]       used;
   logic signed [CW-1:0] lq [4];
   logic signed [CW-1:0] rp [4];
   logic signed [2*CW-1:0] prod_ff [4][4];
   logic signed [SW-1:0] sum_in [4];

   assign lq[0] = req_data.left_w;
   assign lq[1] = req_data.left_x;
   assign lq[2] = req_data.left_y;
   assign lq[3] = req_data.left_z;
   assign rp[0] = req_data.right_w;
   assign rp[1] = req_data.right_x;
   assign rp[2] = req_data.right_y;
   assign rp[3] = req_data.right_z;

   // room for everything already queued plus the one in the multiply stage
   assign used      = {1'b0, fill} + {{QCNTW{1'b0}}, v1_ff};
   assign req_stall = used >= (QCNTW + 1)'(QDEPTH);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   for (genvar c = 0; c < 4; c++) begin : g_comp
      for (genvar i = 0; i < 4; i++) begin : g_term
         always_ff @(posedge clock) begin
            if (accept) begin
               prod_ff[c][i] <= lq[i] * rp[c ^ i];
            end
         end
      end
   end

   // exact sum, then round half up to F fraction bits
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         sum_in[c] = SW'(2 ** (FRAC - 1));
         for (int i = 0; i < 4; i++) begin
            if (NEG_MASK[c][i]) begin
               sum_in[c] = sum_in[c] - SW'(prod_ff[c][i]);
            end else begin
               sum_in[c] = sum_in[c] + SW'(prod_ff[c][i]);
            end
         end
         push_data[c] = sum_in[c][SW-1:FRAC];
      end
   end

   assign push = v1_ff;

endmodule

// ----- sv/qmn_queue.sv -----
// ============================================================================
// qmn_queue
// Short queue of rounded products between the front and back sides.
// ============================================================================
module qmn_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  qmn_pkg::vec_type          push_data,
   input  logic                      pop,
   output logic                      head_valid,
   output qmn_pkg::vec_type          head_data,
   output logic [qmn_pkg::QCNTW-1:0] fill
);
   import qmn_pkg::*;

   vec_type          mem_ff [QDEPTH];
   logic [QPTRW-1:0] wr_ptr_ff;
   logic [QPTRW-1:0] rd_ptr_ff;
   logic [QCNTW-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTRW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTRW'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + QCNTW'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - QCNTW'(1);
         end
      end
   end

   assign head_valid = cnt_ff != '0;
   assign head_data  = mem_ff[rd_ptr_ff];
   assign fill       = cnt_ff;

endmodule

// ----- sv/qmn_back.sv -----
// ============================================================================
// qmn_back
// Execution side: sum of squares, bit-per-stage square root, tolerance test
// and bit-per-stage division of the four components, then the result register.
// ============================================================================
module qmn_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [qmn_pkg::TOLW-1:0] csr_wr_data,
   input  logic                     head_valid,
   input  qmn_pkg::vec_type         head_data,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output qmn_pkg::rsp_type         rsp_data
);
   import qmn_pkg::*;

   logic             en;
   logic [TOLW-1:0]  tol_ff;

   logic             s0_v_ff;
   vec_type          s0_r_ff;
   logic [2*AW-1:0]  s0_sq_ff [4];
   logic             s1_v_ff;
   vec_type          s1_r_ff;
   logic [SQW-1:0]   s1_sum_ff;

   logic             sq_v_ff  [ROOTW];
   sqrt_state_type   sq_st_ff [ROOTW];
   vec_type          sq_r_ff  [ROOTW];

   logic             d_v_ff;
   vec_type          d_r_ff;
   logic [ROOTW-1:0] d_mag_ff;
   logic [ROOTW-1:0] diff_in;
   logic             zero_in;
   logic             skip_in;

   logic             dv_v_ff    [QW];
   div_vec_type      dv_st_ff   [QW];
   logic [ROOTW-1:0] dv_mag_ff  [QW];
   logic             dv_skip_ff [QW];
   logic             dv_zero_ff [QW];
   vec_type          dv_r_ff    [QW];

   logic             rsp_v_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic [CW-1:0]    res_in [4];

   assign en  = !rsp_v_ff || !rsp_stall;
   assign pop = en && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOLW'(TOL_RESET);
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // squares, then their sum
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff <= pop;
         s1_v_ff <= s0_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_r_ff <= head_data;
         for (int c = 0; c < 4; c++) begin
            s0_sq_ff[c] <= (2 * AW)'(abs_r(head_data[c])) * (2 * AW)'(abs_r(head_data[c]));
         end
         s1_r_ff   <= s0_r_ff;
         s1_sum_ff <= SQW'(s0_sq_ff[0]) + SQW'(s0_sq_ff[1])
                    + SQW'(s0_sq_ff[2]) + SQW'(s0_sq_ff[3]);
      end
   end

   // square root, one bit a stage
   for (genvar k = 0; k < ROOTW; k++) begin : g_sqrt
      sqrt_state_type st_in;
      logic           v_in;
      vec_type        r_in;
      if (k == 0) begin : g_first
         assign st_in = '{rad: s1_sum_ff, root: '0, rem: '0};
         assign v_in  = s1_v_ff;
         assign r_in  = s1_r_ff;
      end else begin : g_next
         assign st_in = sq_st_ff[k-1];
         assign v_in  = sq_v_ff[k-1];
         assign r_in  = sq_r_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k] <= 1'b0;
         end else if (en) begin
            sq_v_ff[k] <= v_in;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_st_ff[k] <= sqrt_step(st_in);
            sq_r_ff[k]  <= r_in;
         end
      end
   end

   // round the root to nearest
   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (en) begin
         d_v_ff <= sq_v_ff[ROOTW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_r_ff <= sq_r_ff[ROOTW-1];
         if (sq_st_ff[ROOTW-1].rem > REMW'(sq_st_ff[ROOTW-1].root)) begin
            d_mag_ff <= sq_st_ff[ROOTW-1].root + ROOTW'(1);
         end else begin
            d_mag_ff <= sq_st_ff[ROOTW-1].root;
         end
      end
   end

   assign diff_in = (d_mag_ff > UNIT) ? (d_mag_ff - UNIT) : (UNIT - d_mag_ff);
   assign zero_in = d_mag_ff == '0;
   assign skip_in = zero_in || (diff_in <= ROOTW'(tol_ff));

   // division, one quotient bit a stage in each lane
   for (genvar j = 0; j < QW; j++) begin : g_div
      div_vec_type      st_in;
      div_vec_type      st_out;
      logic             v_in;
      logic [ROOTW-1:0] mag_in;
      logic             skip_v;
      logic             zero_v;
      vec_type          r_in;
      if (j == 0) begin : g_first
         for (genvar c = 0; c < 4; c++) begin : g_lane
            assign st_in[c] = '{rem: DRW'(abs_r(d_r_ff[c])), quo: '0};
         end
         assign v_in   = d_v_ff;
         assign mag_in = d_mag_ff;
         assign skip_v = skip_in;
         assign zero_v = zero_in;
         assign r_in   = d_r_ff;
      end else begin : g_next
         assign st_in  = dv_st_ff[j-1];
         assign v_in   = dv_v_ff[j-1];
         assign mag_in = dv_mag_ff[j-1];
         assign skip_v = dv_skip_ff[j-1];
         assign zero_v = dv_zero_ff[j-1];
         assign r_in   = dv_r_ff[j-1];
      end
      for (genvar c = 0; c < 4; c++) begin : g_step
         assign st_out[c] = div_step(st_in[c], mag_in, (j != 0));
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j] <= 1'b0;
         end else if (en) begin
            dv_v_ff[j] <= v_in;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_st_ff[j]   <= st_out;
            dv_mag_ff[j]  <= mag_in;
            dv_skip_ff[j] <= skip_v;
            dv_zero_ff[j] <= zero_v;
            dv_r_ff[j]    <= r_in;
         end
      end
   end

   // round half away from zero, restore sign, saturate; a skipped result is the saturated product
   always_comb begin
      logic [QW:0]          qr;
      logic signed [RW-1:0] val;
      for (int c = 0; c < 4; c++) begin
         qr  = {1'b0, dv_st_ff[QW-1][c].quo} + (QW + 1)'(1);
         val = RW'(qr[QW:1]);
         if (dv_r_ff[QW-1][c][RW-1]) begin
            val = -val;
         end
         res_in[c] = dv_skip_ff[QW-1] ? saturate(dv_r_ff[QW-1][c]) : saturate(val);
      end
      rsp_in.prod_w         = res_in[0];
      rsp_in.prod_x         = res_in[1];
      rsp_in.prod_y         = res_in[2];
      rsp_in.prod_z         = res_in[3];
      rsp_in.zero_magnitude = dv_zero_ff[QW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         rsp_v_ff <= dv_v_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- sv/qmn_checker.sv -----
// ============================================================================
// qmn_checker
// Port-level checks on the quaternion multiply and normalise block.
// ============================================================================
module qmn_port_checks (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input qmn_pkg::rsp_type rsp_data,
   input logic             rsp_valid,
   input logic             rsp_stall
);
   import qmn_pkg::*;

   // held result must not move
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("request stalled straight after reset");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_magnitude |->
         rsp_data.prod_w == '0 && rsp_data.prod_x == '0 &&
         rsp_data.prod_y == '0 && rsp_data.prod_z == '0)
      else $error("zero magnitude flagged with non-zero product");

endmodule

bind quaternion_multiply_normalise qmn_port_checks u_qmn_port_checks (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);

// ----- sim/qmn_checker.sv -----
// ----------------------------------------------------------------------------
// qmn_checker
// Watches the request and response channels of the quaternion block, works
// out the expected normalised product of every accepted transaction and
// compares each response with the oldest outstanding one.
// ----------------------------------------------------------------------------
module qmn_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  qmn_pkg::req_type         req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  qmn_pkg::rsp_type         rsp_data,
   input  logic                     csr_wr_en,
   input  logic [qmn_pkg::TOLW-1:0] csr_wr_data,
   output int                       fail_count,
   output int                       pending_count,
   output int                       product_count,
   output int                       zero_count,
   output int                       near_unit_count
);
   import qmn_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic [TOLW-1:0] tolerance;
   rsp_type         expected_products[$];

   function automatic longint round_dot(input longint t0, input longint t1,
                                        input longint t2, input longint t3);
      longint s;
      s = t0 + t1 + t2 + t3 + (longint'(1) << (FRAC - 1));
      return s >>> FRAC;
   endfunction

   function automatic longint clamp(input longint v);
      longint hi;
      hi = (longint'(1) << (CW - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // |v| * 2^F / mag, half away from zero
   function automatic longint scale_down(input longint v, input longint mag);
      longint n, q;
      n = (v < 0) ? -v : v;
      q = ((n << (FRAC + 1)) / mag + 1) >> 1;
      return (v < 0) ? -q : q;
   endfunction

   function automatic longint round_root(input longint sq);
      longint r;
      r = longint'($floor($sqrt(real'(sq))));
      while (r * r > sq) r--;
      while ((r + 1) * (r + 1) <= sq) r++;
      return (sq - r * r > r) ? r + 1 : r;
   endfunction

   function automatic rsp_type predict_product(input req_type t,
                                               input logic [TOLW-1:0] tol,
                                               output logic near_unit);
      longint qw, qx, qy, qz, pw, px, py, pz, mag, diff, sq;
      longint r[4];
      rsp_type o;
      logic skip;
      qw = t.left_w;  qx = t.left_x;  qy = t.left_y;  qz = t.left_z;
      pw = t.right_w; px = t.right_x; py = t.right_y; pz = t.right_z;
      r[0] = round_dot(qw * pw, -(qx * px), -(qy * py), -(qz * pz));
      r[1] = round_dot(qw * px, qx * pw, qy * pz, -(qz * py));
      r[2] = round_dot(qw * py, -(qx * pz), qy * pw, qz * px);
      r[3] = round_dot(qw * pz, qx * py, -(qy * px), qz * pw);
      sq = 0;
      for (int i = 0; i < 4; i++) sq += r[i] * r[i];
      mag  = round_root(sq);
      diff = mag - (longint'(1) << FRAC);
      if (diff < 0) diff = -diff;
      near_unit = (mag != 0) && (diff <= longint'(tol));
      skip = (mag == 0) || near_unit;
      o.prod_w = CW'(clamp(skip ? r[0] : scale_down(r[0], mag)));
      o.prod_x = CW'(clamp(skip ? r[1] : scale_down(r[1], mag)));
      o.prod_y = CW'(clamp(skip ? r[2] : scale_down(r[2], mag)));
      o.prod_z = CW'(clamp(skip ? r[3] : scale_down(r[3], mag)));
      o.zero_magnitude = (mag == 0);
      return o;
   endfunction

   assign pending_count = expected_products.size();

   always_ff @(posedge clock) begin
      rsp_type want;
      logic    near_unit;
      int      errs;
      errs = 0;
      if (reset) begin
         tolerance <= TOLW'(TOL_RESET);
         expected_products.delete();
         fail_count <= 0;
         product_count <= 0;
         zero_count <= 0;
         near_unit_count <= 0;
      end else begin
         if (csr_wr_en) tolerance <= csr_wr_data;
         if (req_valid && !req_stall) begin
            want = predict_product(req_data, tolerance, near_unit);
            expected_products.push_back(want);
            zero_count <= zero_count + int'(want.zero_magnitude);
            near_unit_count <= near_unit_count + int'(near_unit);
         end
         if (rsp_valid && !rsp_stall) begin
            product_count <= product_count + 1;
            if (expected_products.size() == 0) begin
               $error("unexpected response %h", rsp_data);
               errs++;
            end else begin
               want = expected_products.pop_front();
               if (rsp_data.prod_w !== want.prod_w) begin
                  $error("prod_w expected %0d got %0d", want.prod_w, rsp_data.prod_w);
                  errs++;
               end
               if (rsp_data.prod_x !== want.prod_x) begin
                  $error("prod_x expected %0d got %0d", want.prod_x, rsp_data.prod_x);
                  errs++;
               end
               if (rsp_data.prod_y !== want.prod_y) begin
                  $error("prod_y expected %0d got %0d", want.prod_y, rsp_data.prod_y);
                  errs++;
               end
               if (rsp_data.prod_z !== want.prod_z) begin
                  $error("prod_z expected %0d got %0d", want.prod_z, rsp_data.prod_z);
                  errs++;
               end
               if (rsp_data.zero_magnitude !== want.zero_magnitude) begin
                  $error("zero_magnitude expected %0b got %0b",
                         want.zero_magnitude, rsp_data.zero_magnitude);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule

// ----- sim/quaternion_multiply_normalise_tb.sv -----
// ----------------------------------------------------------------------------
// quaternion_multiply_normalise_tb
// Drives quaternion pairs into the block, sweeps the unit tolerance through
// several settings between idle phases and gives the verdict from the
// checker's failure count.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalise_tb;
   import qmn_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 5000;   // cycles without any transaction
   localparam int DRAIN_CYCLES = 60;     // a bit over the pipeline latency
   localparam int ONE          = 1 << FRAC;
   localparam int BURST_ITEMS  = 120;    // more than the block can hold
   localparam int PHASE_ITEMS  = 264;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_type         req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_type         rsp_data;
   logic            csr_wr_en;
   logic [TOLW-1:0] csr_wr_data;
   int              fail_count, pending_count, product_count;
   int              zero_count, near_unit_count;
   int              idle_cycles;
   logic            long_hold;   // forces a long receiver stall

   quaternion_multiply_normalise dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   qmn_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .product_count(product_count), .zero_count(zero_count),
      .near_unit_count(near_unit_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // No gap half the time, otherwise mostly short gaps, now and then a long one.
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver: random stalls, plus a long hold when the sender asks for one.
   initial begin
      int hold;
      rsp_stall = 1'b1;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (200) @(posedge clock);
            long_hold = 1'b0;
         end
         hold = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
         rsp_stall <= (hold != 0);
         @(posedge clock);
         if (hold > 1) repeat (hold - 1) @(posedge clock);
      end
   end

   // Watchdog: gives up when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (req_valid == 1'b0 && pending_count == 0)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Component value biased toward the corners and near-unit magnitudes.
   function automatic logic signed [CW-1:0] pick_component();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 0;
         3: return CW'($urandom_range(0, 2 * ONE) - ONE);
         4: return CW'($urandom_range(0, 512) - 256);
         default: return CW'($urandom());
      endcase
   endfunction

   // Unit quaternion scaled so the product lands close to magnitude one.
   function automatic req_type near_unit_pair();
      req_type t;
      int k, j;
      t = '0;
      k = $urandom_range(0, 3);
      j = $urandom_range(0, 3);
      t.left_w = (k == 0) ? CW'(ONE + $urandom_range(0, 40) - 20) : CW'($urandom_range(0, 8));
      t.left_x = (k == 1) ? CW'(-ONE) : 0;
      t.left_y = (k == 2) ? CW'(ONE - $urandom_range(0, 30)) : 0;
      t.left_z = (k == 3) ? CW'(ONE) : 0;
      t.right_w = (j == 0) ? CW'(ONE) : 0;
      t.right_x = (j == 1) ? CW'(ONE + $urandom_range(0, 60) - 30) : 0;
      t.right_y = (j == 2) ? CW'(-ONE) : 0;
      t.right_z = (j == 3) ? CW'(ONE) : CW'($urandom_range(0, 4));
      return t;
   endfunction

   function automatic req_type random_pair();
      req_type t;
      if ($urandom_range(0, 3) == 0) return near_unit_pair();
      if ($urandom_range(0, 9) == 0) return req_type'({$urandom(), $urandom(),
                                                      $urandom(), $urandom()});
      t.left_w = pick_component();  t.left_x = pick_component();
      t.left_y = pick_component();  t.left_z = pick_component();
      t.right_w = pick_component(); t.right_x = pick_component();
      t.right_y = pick_component(); t.right_z = pick_component();
      return t;
   endfunction

   // Offer one transaction and wait for it to be taken.
   task automatic send_pair(input req_type t);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [TOLW-1:0] tol);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= tol;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic [TOLW-1:0] tol_plan[5];
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      long_hold   = 1'b0;
      tol_plan = '{14'd0, 14'd16383, 14'd1, 14'd300, 14'd16};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset tolerance, corners, zero, identity, each axis.
      send_pair('0);                                       // zero magnitude
      send_pair('{ONE, 0, 0, 0, ONE, 0, 0, 0});            // identity product
      send_pair('{0, ONE, 0, 0, 0, ONE, 0, 0});            // i*i = -1
      send_pair('{0, 0, ONE, 0, 0, 0, 0, ONE});            // j*k = i
      send_pair('{0, 0, 0, ONE, 0, ONE, 0, 0});            // k*i = j
      send_pair('{ONE + 16, 0, 0, 0, ONE, 0, 0, 0});       // edge of tolerance
      send_pair('{ONE + 17, 0, 0, 0, ONE, 0, 0, 0});       // just outside
      send_pair({8{16'sh7fff}});
      send_pair({8{16'sh8000}});
      send_pair('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                  16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
      send_pair('{1, 0, 0, 0, 1, 0, 0, 0});                // rounds to zero
      send_pair('{1, 1, 1, 1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
      send_pair('{16'hffff, 16'hffff, 16'hffff, 16'hffff,
                  16'hffff, 16'hffff, 16'hffff, 16'hffff});
      send_pair('{ONE / 2, ONE / 2, ONE / 2, ONE / 2, 3, -7, 11, -13});

      // Long receiver hold while the sender keeps offering: fills the block.
      long_hold = 1'b1;
      for (int n = 0; n < BURST_ITEMS; n++) begin
         req_valid <= 1'b1;
         req_data  <= random_pair();
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      drain_block();   // sender waits for every response

      // Random phases, one tolerance setting each.
      foreach (tol_plan[p]) begin
         write_tolerance(tol_plan[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) send_pair(random_pair());
         drain_block();
      end

      $display("covered %0d responses, %0d zero-magnitude, %0d near-unit skips,",
               product_count, zero_count, near_unit_count);
      $display("five tolerance settings including 0 and 16383, with long stalls");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// ----- files.f -----
sv/qmn_pkg.sv
sv/qmn_front.sv
sv/qmn_queue.sv
sv/qmn_back.sv
sv/quaternion_multiply_normalise.sv
sv/qmn_checker.sv
sim/qmn_checker.sv
sim/quaternion_multiply_normalise_tb.sv
